### src/silence_run_length_smoother_top_defines.svh
// assertion macros shared by the silence run length smoother modules
// no dependencies; included by files that carry concurrent assertions
`ifndef SILENCE_RUN_LENGTH_SMOOTHER_TOP_DEFINES_SVH
`define SILENCE_RUN_LENGTH_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication
`define SLRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/slrs_pkg.sv
// shared types and constants for the silence run length smoother
// no dependencies
package slrs_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int SAMPLE_BITS        = 16;
    localparam int THRESHOLD_BITS     = 16;
    localparam int LIMIT_BITS         = 32;
    localparam int RUN_LENGTH_BITS    = 32;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 32;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_LEVEL_THRESHOLD = cfg_index_t'(0);
    localparam cfg_index_t CFG_SILENCE_LIMIT   = cfg_index_t'(1);

    typedef enum logic [1:0] {
        OP_CLASS  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ADD    = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [THRESHOLD_BITS-1:0] level_threshold;
        logic [LIMIT_BITS-1:0]     silence_limit;
    } slrs_cfg_t;

    typedef struct packed {
        op_kind_t                   op_kind;
        logic [RUN_LENGTH_BITS-1:0] run_length;
        logic                       start_above;
    } slrs_result_t;

endpackage

### src/slrs_cfg_regs.sv
// configuration registers: level threshold and silence limit
// depends on slrs_pkg
module slrs_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  slrs_pkg::cfg_index_t                cfg_index,
    input  logic [slrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output slrs_pkg::slrs_cfg_t                 cfg
);
    import slrs_pkg::*;

    slrs_cfg_t cfg_reg;
    slrs_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEVEL_THRESHOLD: cfg_next.level_threshold = cfg_data[THRESHOLD_BITS-1:0];
                CFG_SILENCE_LIMIT:   cfg_next.silence_limit   = cfg_data[LIMIT_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/slrs_tracker.sv
// run tracking: sample classification, run counter, merge decision
// depends on slrs_pkg and the assertion macro header
`include "silence_run_length_smoother_top_defines.svh"

module slrs_tracker #(
    parameter int COUNT_BITS = slrs_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  slrs_pkg::slrs_cfg_t                  cfg,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [slrs_pkg::SAMPLE_BITS-1:0]     sample,
    input  logic                                 start_of_stream,
    output logic                                 push,
    output slrs_pkg::slrs_result_t               push_data
);
    import slrs_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > RUN_LENGTH_BITS) ? COUNT_BITS : RUN_LENGTH_BITS;

    logic                  current_above_reg, current_above_next;
    logic [COUNT_BITS-1:0] run_count_reg, run_count_next;
    logic                  merge_open_reg, merge_open_next;
    logic                  has_entry_reg, has_entry_next;

    logic                  accept;
    logic [SAMPLE_BITS:0]  sample_ext;
    logic [SAMPLE_BITS:0]  magnitude;
    logic                  loud;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_BITS-1:0]   count_ext;
    logic [CMP_BITS-1:0]   limit_ext;
    logic [CMP_BITS-1:0]   len_max_ext;
    logic [RUN_LENGTH_BITS-1:0] run_len_sat;
    logic                  merge;

    assign accept      = in_valid && in_ready;
    assign sample_ext  = {sample[SAMPLE_BITS-1], sample};
    assign magnitude   = sample[SAMPLE_BITS-1] ? (~sample_ext + 1'b1) : sample_ext;
    assign loud        = magnitude > {1'b0, cfg.level_threshold};
    assign count_inc   = (run_count_reg == {COUNT_BITS{1'b1}}) ? run_count_reg
                                                              : run_count_reg + 1'b1;
    assign count_ext   = CMP_BITS'(run_count_reg);
    assign limit_ext   = CMP_BITS'(cfg.silence_limit);
    assign len_max_ext = CMP_BITS'({RUN_LENGTH_BITS{1'b1}});
    assign run_len_sat = (count_ext > len_max_ext) ? {RUN_LENGTH_BITS{1'b1}}
                                                   : count_ext[RUN_LENGTH_BITS-1:0];
    assign merge       = (current_above_reg && merge_open_reg) ||
                         (!current_above_reg && has_entry_reg && (count_ext <= limit_ext));

    always_comb
    begin
        current_above_next = current_above_reg;
        run_count_next     = run_count_reg;
        merge_open_next    = merge_open_reg;
        has_entry_next     = has_entry_reg;
        push               = 1'b0;
        push_data          = '{op_kind: OP_CLASS, run_length: '0, start_above: 1'b0};
        if (accept)
        begin
            current_above_next = loud;
            if (start_of_stream)
            begin
                run_count_next        = COUNT_BITS'(1);
                merge_open_next       = 1'b0;
                has_entry_next        = 1'b0;
                push                  = 1'b1;
                push_data.start_above = loud;
            end
            else if (loud != current_above_reg)
            begin
                run_count_next       = COUNT_BITS'(1);
                push                 = 1'b1;
                push_data.run_length = run_len_sat;
                if (merge)
                begin
                    merge_open_next   = !merge_open_reg;
                    push_data.op_kind = OP_ADD;
                end
                else
                begin
                    has_entry_next    = 1'b1;
                    push_data.op_kind = OP_APPEND;
                end
            end
            else
            begin
                run_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_above_reg <= 1'b0;
            run_count_reg     <= '0;
            merge_open_reg    <= 1'b0;
            has_entry_reg     <= 1'b0;
        end
        else
        begin
            current_above_reg <= current_above_next;
            run_count_reg     <= run_count_next;
            merge_open_reg    <= merge_open_next;
            has_entry_reg     <= has_entry_next;
        end
    end

    `SLRS_ASSERT_NEXT(a_start_clears, accept && start_of_stream,
        run_count_reg == COUNT_BITS'(1) && !merge_open_reg && !has_entry_reg,
        "start item did not reset run state")
    `SLRS_ASSERT_NEXT(a_count_nonzero, accept, run_count_reg != '0,
        "run counter zero after a transfer")
    `SLRS_ASSERT_NOW(a_push_needs_accept, push, accept,
        "result produced without an input transfer")

endmodule

### src/slrs_out_buffer.sv
// result register with a skid stage so one more result can enter while output stalls
// depends on slrs_pkg and the assertion macro header
`include "silence_run_length_smoother_top_defines.svh"

module slrs_out_buffer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  slrs_pkg::slrs_result_t  push_data,
    output logic                    space,
    output logic                    out_valid,
    input  logic                    out_ready,
    output slrs_pkg::slrs_result_t  out_data
);
    import slrs_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    slrs_result_t out_data_reg, out_data_next;
    slrs_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `SLRS_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid stage full while result register empty")
    `SLRS_ASSERT_NOW(a_no_push_when_full, skid_valid_reg, !push,
        "result pushed into full buffer")
    `SLRS_ASSERT_NEXT(a_skid_moves_up, skid_valid_reg && pop,
        out_valid_reg && out_data_reg == $past(skid_data_reg),
        "skid entry lost on output transfer")

endmodule

### src/silence_run_length_smoother_top.sv
// Silence run length smoother. Each input transfer carries one signed sample; it is
// classified as loud when its magnitude exceeds level_threshold (register 0), and runs
// of equal class are counted. On a class change the finished run goes out as an append
// or, for short silence runs up to silence_limit (register 1) and the loud run closing
// them, as an add onto the last entry; a start_of_stream sample reports its class and
// restarts the run state. One sample is taken every cycle: classification, counting
// and the merge decision finish in the cycle of the transfer, and results pass through
// a result register backed by a one-entry skid stage, so input stalls only when both
// hold untaken results. chunk_end is ignored. The last unfinished run is not reported.
module silence_run_length_smoother_top #(
    parameter int COUNT_BITS = slrs_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  slrs_pkg::cfg_index_t                     cfg_index,
    input  logic [slrs_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [slrs_pkg::SAMPLE_BITS-1:0]         sample,
    input  logic                                     start_of_stream,
    input  logic                                     chunk_end,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output slrs_pkg::op_kind_t                       op_kind,
    output logic [slrs_pkg::RUN_LENGTH_BITS-1:0]     run_length,
    output logic                                     start_above
);
    import slrs_pkg::*;

    slrs_cfg_t    cfg;
    logic         push;
    slrs_result_t push_data;
    slrs_result_t out_data;

    slrs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slrs_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .start_of_stream (start_of_stream),
        .push            (push),
        .push_data       (push_data)
    );

    slrs_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign op_kind     = out_data.op_kind;
    assign run_length  = out_data.run_length;
    assign start_above = out_data.start_above;

endmodule
